// File: sv/rgb_to_gray_half_downsample_assert.svh
// ----------------------------------------------------------------------------
// rgb_to_gray_half_downsample assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_GRAY_HALF_DOWNSAMPLE_ASSERT_SVH
`define RGB_TO_GRAY_HALF_DOWNSAMPLE_ASSERT_SVH

// same-cycle implication
`define RGD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgd: same-cycle check failed");

// next-cycle implication
`define RGD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgd: next-cycle check failed");

`endif

// File: sv/rgd_pkg.sv
// ----------------------------------------------------------------------------
// rgd_pkg
// Shared types and constants for the RGB-to-gray 2x2 downsampler.
// ----------------------------------------------------------------------------
package rgd_pkg;

    // channel and register widths
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned SUM3_W    = 10;
    localparam int unsigned PAIR_W    = 9;
    localparam int unsigned TOTAL_W   = 10;
    localparam int unsigned FW_W      = 12;
    localparam int unsigned FH_W      = 13;
    localparam int unsigned ROW_W     = 12;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;

    // divide-by-three reciprocal: floor(x/3) = (x * 0xAAAB) >> 17
    localparam int unsigned GRAY_MUL_W = 16;
    localparam logic [GRAY_MUL_W-1:0] GRAY_MUL = 16'hAAAB;
    localparam int unsigned GRAY_SHIFT = 17;
    localparam int unsigned PROD_W     = SUM3_W + GRAY_MUL_W;

    // register reset values and height limits
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [FH_W-1:0] MIN_HEIGHT       = 13'd2;
    localparam logic [FH_W-1:0] MAX_HEIGHT       = 13'd4096;

    // register map (word index)
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

// File: sv/rgb_to_gray_half_downsample.sv
// ----------------------------------------------------------------------------
// rgb_to_gray_half_downsample
// RGB to gray conversion with a 2x2 box average down to half resolution.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one RGB pixel per transfer in
//   raster order. Output channel (out_valid/out_ready) gives one half-res
//   gray pixel per 2x2 block, with row_end / frame_end marks.
//   An odd last column or odd last row is consumed and gives no result.
//   APB port: frame_width at 0x0, frame_height at 0x4; a write restarts the
//   frame at row 0, column 0. Write only while the block is idle.
//   Path: a result passes through the stage-1 registers and then the output
//   register after the transfer of the pixel that completes its block.
//   Throughput: one pixel per cycle while no result stalls; the line store
//   is a one-write, one-read memory: read at transfer, written one stage later.
//   Reset: counters, valid bits and config reset to defaults; the line store is not
//   cleared (an even row always writes an entry before the odd row reads it).
//   Stall: a result waits in the output register; the input keeps flowing
//   until a second result is ready behind it, then in_ready drops.
// ----------------------------------------------------------------------------
module rgb_to_gray_half_downsample #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // pixel input
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rgd_pkg::PIX_W-1:0]   red_level,
    input  logic [rgd_pkg::PIX_W-1:0]   green_level,
    input  logic [rgd_pkg::PIX_W-1:0]   blue_level,
    // half-res output
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rgd_pkg::PIX_W-1:0]   half_gray,
    output logic                        row_end,
    output logic                        frame_end,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgd_pkg::APB_AW-1:0]  paddr,
    input  logic [rgd_pkg::APB_DW-1:0]  pwdata,
    output logic [rgd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_W  = (EW_W > rgd_pkg::FW_W) ? EW_W : rgd_pkg::FW_W;
    localparam int unsigned HH_W   = rgd_pkg::FH_W - 1;

    // config registers
    logic [rgd_pkg::FW_W-1:0]   frame_width_reg;
    logic [rgd_pkg::FH_W-1:0]   frame_height_reg;
    logic                       cfg_wr;
    rgd_pkg::reg_idx_t          cfg_idx;

    // frame position
    logic [COL_W-1:0]           col_reg, col_next;
    logic [rgd_pkg::ROW_W-1:0]  row_reg, row_next;

    // stage 1 (pair / block stage)
    logic                       s1_valid_reg;
    logic                       s1_even_reg;
    logic                       s1_pair_reg;
    logic                       s1_store_reg;
    logic                       s1_emit_reg;
    logic                       s1_rend_reg;
    logic                       s1_fend_reg;
    logic [ADDR_W-1:0]          s1_idx_reg;
    logic [rgd_pkg::PIX_W-1:0]  s1_gray_reg;
    logic [rgd_pkg::PIX_W-1:0]  held_even_reg;
    logic [rgd_pkg::PAIR_W-1:0] rd_data_reg;
    logic                       s1_go;

    // output register
    logic                       out_valid_reg;
    logic [rgd_pkg::PIX_W-1:0]  half_gray_reg;
    logic                       row_end_reg;
    logic                       frame_end_reg;

    // line store of pair sums from the even row
    logic [rgd_pkg::PAIR_W-1:0] line_mem [LINE_DEPTH];

    // combinational helpers
    logic [CMP_W-1:0]           fw_ext;
    logic [EW_W-1:0]            eff_w;
    logic [EW_W-1:0]            half_w;
    logic [rgd_pkg::FH_W-1:0]   eff_h;
    logic [HH_W-1:0]            half_h;
    logic [EW_W-1:0]            col_half;
    logic [HH_W-1:0]            row_half;
    logic [EW_W:0]              col_inc;
    logic [rgd_pkg::FH_W-1:0]   row_inc;
    logic                       in_xfer;
    logic                       pair_ok;
    logic                       row_ok;
    logic                       rend;
    logic [rgd_pkg::SUM3_W-1:0] sum3;
    logic [rgd_pkg::PROD_W-1:0] prod;
    logic [rgd_pkg::PIX_W-1:0]  gray;
    logic [rgd_pkg::PAIR_W-1:0] pair_sum;
    logic [rgd_pkg::TOTAL_W-1:0] total;

    // APB decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = rgd_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            rgd_pkg::REG_FRAME_WIDTH:
                prdata = rgd_pkg::APB_DW'(frame_width_reg);
            rgd_pkg::REG_FRAME_HEIGHT:
                prdata = rgd_pkg::APB_DW'(frame_height_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rgd_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rgd_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                rgd_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= pwdata[rgd_pkg::FW_W-1:0];
                rgd_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[rgd_pkg::FH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // saturated frame size
    always_comb
    begin
        fw_ext = CMP_W'(frame_width_reg);
        if (fw_ext < CMP_W'(2))
            eff_w = EW_W'(2);
        else if (fw_ext > CMP_W'(MAX_WIDTH))
            eff_w = EW_W'(MAX_WIDTH);
        else
            eff_w = EW_W'(fw_ext);

        if (frame_height_reg < rgd_pkg::MIN_HEIGHT)
            eff_h = rgd_pkg::MIN_HEIGHT;
        else if (frame_height_reg > rgd_pkg::MAX_HEIGHT)
            eff_h = rgd_pkg::MAX_HEIGHT;
        else
            eff_h = frame_height_reg;
    end

    assign half_w   = eff_w >> 1;
    assign half_h   = eff_h[rgd_pkg::FH_W-1:1];
    assign col_half = EW_W'(col_reg >> 1);
    assign row_half = HH_W'(row_reg[rgd_pkg::ROW_W-1:1]);

    // position decode for the incoming pixel
    assign pair_ok = col_reg[0] && (col_half < half_w);
    assign row_ok  = row_half < half_h;
    assign rend    = col_half == (half_w - EW_W'(1));

    // gray = floor((r+g+b)/3)
    assign sum3 = rgd_pkg::SUM3_W'(red_level) + rgd_pkg::SUM3_W'(green_level)
                + rgd_pkg::SUM3_W'(blue_level);
    assign prod = rgd_pkg::PROD_W'(sum3) * rgd_pkg::PROD_W'(rgd_pkg::GRAY_MUL);
    assign gray = prod[rgd_pkg::GRAY_SHIFT +: rgd_pkg::PIX_W];

    // handshake: stage 1 retires unless its result is blocked
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_xfer  = in_valid && in_ready;

    // raster counters
    assign col_inc = (EW_W+1)'(col_reg) + (EW_W+1)'(1);
    assign row_inc = rgd_pkg::FH_W'(row_reg) + rgd_pkg::FH_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_xfer)
        begin
            if (col_inc >= (EW_W+1)'(eff_w))
            begin
                col_next = '0;
                if (row_inc >= eff_h)
                    row_next = '0;
                else
                    row_next = row_inc[rgd_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload, loaded on input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_even_reg  <= !col_reg[0];
            s1_pair_reg  <= pair_ok;
            s1_store_reg <= pair_ok && !row_reg[0];
            s1_emit_reg  <= pair_ok && row_reg[0] && row_ok;
            s1_rend_reg  <= rend;
            s1_fend_reg  <= rend && (row_half == (half_h - HH_W'(1)));
            s1_idx_reg   <= col_half[ADDR_W-1:0];
            s1_gray_reg  <= gray;
        end
    end

    // held gray of the even column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_even_reg <= '0;
        else if (s1_go && s1_even_reg)
            held_even_reg <= s1_gray_reg;
    end

    // line store: read at input transfer, write back from stage 1.
    // An odd-row read of an entry always trails the even-row write of that
    // entry by at least one full row, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_store_reg)
            line_mem[s1_idx_reg] <= pair_sum;
        if (in_xfer && pair_ok && row_reg[0])
            rd_data_reg <= line_mem[col_half[ADDR_W-1:0]];
    end

    // pair and block sums
    assign pair_sum = rgd_pkg::PAIR_W'(held_even_reg) + rgd_pkg::PAIR_W'(s1_gray_reg);
    assign total    = rgd_pkg::TOTAL_W'(rd_data_reg) + rgd_pkg::TOTAL_W'(pair_sum);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_emit_reg && s1_pair_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            half_gray_reg <= total[rgd_pkg::TOTAL_W-1:2];
            row_end_reg   <= s1_rend_reg;
            frame_end_reg <= s1_fend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign half_gray = half_gray_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// File: sv/rgd_checker.sv
// ----------------------------------------------------------------------------
// rgd_checker
// Port-level checks for rgb_to_gray_half_downsample, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_gray_half_downsample_assert.svh"

module rgd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [rgd_pkg::PIX_W-1:0]   half_gray,
    input  logic                        row_end,
    input  logic                        frame_end,
    input  logic                        pready
);

    // a stalled result holds its value
    `RGD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(half_gray))

    // the frame always closes on a row end
    `RGD_ASSERT_IMP(a_frame_on_row, clk, rst_n, out_valid && frame_end, row_end)

    // with an empty output register the input never stalls
    `RGD_ASSERT_IMP(a_in_free, clk, rst_n, !out_valid, in_ready)

    // config port has no wait states
    `RGD_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind rgb_to_gray_half_downsample rgd_checker u_rgd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .half_gray (half_gray),
    .row_end   (row_end),
    .frame_end (frame_end),
    .pready    (pready)
);
